[rtl/ffha_pkg.sv]
// Shared types and constants for the first-fit heap allocator.
// No dependencies.
package ffha_pkg;
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_INIT  = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam int OFS_W = 25;

    typedef struct packed {
        logic [OFS_W-1:0] start;
        logic [OFS_W-1:0] size;
        logic             free;
    } t_entry;
endpackage

[rtl/ffha_table.sv]
// Block table memory: one synchronous read port, one write port.
// Depends on ffha_pkg.
module ffha_table import ffha_pkg::*; #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic         i_clk,
    input  logic         i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry       i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry       o_rdata
);
    t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/first_fit_heap_allocator_core.sv]
// Top level of the first-fit heap allocator: sequencer around the block table.
// Depends on ffha_pkg and ffha_table.
// A request walks the table one entry at a time: a search pass reads an entry and
// checks it on the next cycle, and a split or merge shifts the tail of the table one
// entry at a time (read, then write). A successful allocate or free searches, shifts
// any entries that the edit needs, and ends with a final write. Init, zero-size,
// rejected-free and unknown requests raise no busy and strobe their result in the cycle
// after acceptance. For a walked request busy rises the cycle after acceptance and
// drops in the cycle that carries the result strobe; the result is presented for one
// cycle and the receiver cannot stall it. Reset loads the table with one free block.
module first_fit_heap_allocator_core import ffha_pkg::*; #(
    parameter int MAX_BLOCKS        = 256,
    parameter int HEAP_BYTES        = 4194304,
    parameter int ALIGN_BYTES       = 16,
    parameter int HEADER_BYTES      = 16,
    parameter int MIN_PAYLOAD_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic [1:0]  i_req_type,
    input  logic [22:0] i_request_size,
    input  logic [31:0] i_free_address,
    output logic        o_result_valid,
    output logic [31:0] o_result_address,
    output logic [1:0]  o_status
);
    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int ALW = $clog2(ALIGN_BYTES);
    localparam logic [OFS_W-1:0] HEAP = OFS_W'(HEAP_BYTES);
    localparam logic [OFS_W-1:0] HDR  = OFS_W'(HEADER_BYTES);
    localparam logic [OFS_W-1:0] SPLIT_MIN =
        OFS_W'(HEADER_BYTES + MIN_PAYLOAD_BYTES + ALIGN_BYTES - 1);
    localparam logic [OFS_W-1:0] AMASK = ~OFS_W'(ALIGN_BYTES - 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD    = 10'b0000000010,
        S_CHK   = 10'b0000000100,
        S_SHR   = 10'b0000001000,
        S_SHW   = 10'b0000010000,
        S_FIN   = 10'b0000100000,
        S_MRD   = 10'b0001000000,
        S_MCHK  = 10'b0010000000,
        S_DLR   = 10'b0100000000,
        S_DLW   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [31:0] r_base;
    logic [CW-1:0] r_count, n_count;
    logic [1:0] r_kind;
    logic [OFS_W-1:0] r_want, r_hdr;
    logic [CW-1:0] r_k, n_k;        // current scan / target index
    logic [CW-1:0] r_j, n_j;        // shift cursor
    t_entry r_cur, n_cur;           // working copy of entry k
    t_entry r_ins, n_ins;           // split remainder
    logic r_ov, n_ov;
    logic [31:0] r_oaddr, n_oaddr;
    logic [1:0] r_ost, n_ost;
    logic [1:0] r_mph, n_mph;       // merge phase: 0 fwd, 1 back, 2 fwd again

    logic we;
    logic [AW-1:0] waddr, raddr;
    t_entry wdata, rdata;
    logic [CW-1:0] rptr;

    ffha_table #(.DEPTH(MAX_BLOCKS), .AW(AW)) u_table (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign busy = (r_state != S_IDLE);
    assign o_result_valid = r_ov;
    assign o_result_address = r_oaddr;
    assign o_status = r_ost;
    assign raddr = rptr[AW-1:0];

    logic accept;
    logic [OFS_W-1:0] in_want, fofs, spare;
    logic [31:0] off32;
    logic fbad;
    assign accept = start && !busy;
    assign in_want = (OFS_W'(i_request_size) + OFS_W'(ALIGN_BYTES - 1)) & AMASK;
    assign off32 = i_free_address - r_base;
    assign fofs = off32[OFS_W-1:0];
    assign fbad = (i_free_address == 32'd0) || (i_free_address[ALW-1:0] != '0)
               || (off32 >= 32'(HEAP_BYTES)) || (off32 < 32'(HEADER_BYTES));
    assign spare = rdata.size - r_want;

    always_comb begin
        n_state = r_state; n_count = r_count; n_k = r_k; n_j = r_j;
        n_cur = r_cur; n_ins = r_ins;
        n_ov = 1'b0; n_oaddr = r_oaddr; n_ost = r_ost; n_mph = r_mph;
        we = 1'b0; waddr = r_k[AW-1:0]; wdata = r_cur; rptr = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_k = '0; n_mph = 2'd0;
                    n_oaddr = '0;
                    priority if (i_req_type == REQ_INIT) begin
                        we = 1'b1; waddr = '0;
                        wdata = '{start: '0, size: HEAP - HDR, free: 1'b1};
                        n_count = CW'(1);
                        n_ost = ST_DONE; n_ov = 1'b1;
                    end else if (i_req_type == REQ_ALLOC && i_request_size == '0) begin
                        n_ost = ST_ZERO; n_ov = 1'b1;
                    end else if (i_req_type == REQ_FREE && fbad) begin
                        n_ost = ST_IGNORED; n_ov = 1'b1;
                    end else if (i_req_type == REQ_ALLOC || i_req_type == REQ_FREE) begin
                        n_state = S_RD;
                    end else begin
                        n_ost = ST_IGNORED; n_ov = 1'b1;
                    end
                end
            end
            S_RD: begin
                if (r_k >= r_count) begin
                    n_ost = (r_kind == REQ_ALLOC) ? ST_NOMEM : ST_IGNORED;
                    n_ov = 1'b1; n_state = S_IDLE;
                end else begin
                    rptr = r_k; n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = S_RD; n_k = r_k + CW'(1);
                if (r_kind == REQ_ALLOC) begin
                    if (rdata.free && rdata.size >= r_want) begin
                        n_cur = '{start: rdata.start, size: r_want, free: 1'b0};
                        n_oaddr = r_base + 32'(rdata.start) + 32'(HEADER_BYTES);
                        n_k = r_k;
                        if (spare >= SPLIT_MIN && r_count < CW'(MAX_BLOCKS)) begin
                            n_ins.start = rdata.start + HDR + r_want;
                            n_ins.size = (spare - HDR) & AMASK;
                            n_ins.free = 1'b1;
                            if (n_ins.start + HDR > HEAP) begin
                                n_ost = ST_NOMEM; n_ov = 1'b1; n_oaddr = '0;
                                n_state = S_IDLE;
                            end else begin
                                n_j = r_count; n_state = S_SHR;
                            end
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                end else if (rdata.start == r_hdr) begin
                    if (rdata.free) begin
                        n_ost = ST_IGNORED; n_ov = 1'b1; n_state = S_IDLE;
                    end else begin
                        n_k = r_k;
                        n_cur = '{start: rdata.start, size: rdata.size, free: 1'b1};
                        n_state = S_MRD;
                    end
                end
            end
            // shift entries k+1.. up by one, from the top down
            S_SHR: begin
                if (r_j == r_k + CW'(1)) begin
                    we = 1'b1; waddr = r_j[AW-1:0]; wdata = r_ins;
                    n_count = r_count + CW'(1); n_state = S_FIN;
                end else begin
                    rptr = r_j - CW'(1); n_state = S_SHW;
                end
            end
            S_SHW: begin
                we = 1'b1; waddr = r_j[AW-1:0]; wdata = rdata;
                n_j = r_j - CW'(1); n_state = S_SHR;
            end
            S_FIN: begin
                we = 1'b1; waddr = r_k[AW-1:0]; wdata = r_cur;
                n_ost = ST_DONE; n_ov = 1'b1; n_state = S_IDLE;
            end
            // merge: r_cur holds entry k; read neighbour
            S_MRD: begin
                if (r_mph == 2'd1) begin
                    if (r_k == '0) begin
                        n_state = S_FIN;
                    end else begin
                        rptr = r_k - CW'(1); n_state = S_MCHK;
                    end
                end else if (r_k + CW'(1) < r_count) begin
                    rptr = r_k + CW'(1); n_state = S_MCHK;
                end else if (r_mph == 2'd0) begin
                    n_mph = 2'd1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_MCHK: begin
                if (r_mph == 2'd1) begin
                    if (rdata.free && rdata.start + HDR + rdata.size == r_cur.start) begin
                        n_cur = '{start: rdata.start, size: rdata.size + HDR + r_cur.size,
                                  free: 1'b1};
                        n_j = r_k; n_k = r_k - CW'(1);
                        n_mph = 2'd2; n_state = S_DLR;
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (rdata.free && r_cur.start + HDR + r_cur.size == rdata.start) begin
                    n_cur.size = r_cur.size + HDR + rdata.size;
                    n_j = r_k + CW'(1); n_state = S_DLR;
                end else if (r_mph == 2'd0) begin
                    n_mph = 2'd1; n_state = S_MRD;
                end else begin
                    n_state = S_FIN;
                end
            end
            // drop entry j: move j+1 down to j
            S_DLR: begin
                if (r_j + CW'(1) >= r_count) begin
                    n_count = r_count - CW'(1); n_state = S_MRD;
                end else begin
                    rptr = r_j + CW'(1); n_state = S_DLW;
                end
            end
            S_DLW: begin
                we = 1'b1; waddr = r_j[AW-1:0]; wdata = rdata;
                n_j = r_j + CW'(1); n_state = S_DLR;
            end
            default: n_state = S_IDLE;
        endcase
        if (!i_rst_n) begin
            we = 1'b1; waddr = '0;
            wdata = '{start: '0, size: HEAP - HDR, free: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base <= '0;
            r_count <= CW'(1);
            r_ov <= 1'b0;
            r_ost <= ST_DONE;
            r_oaddr <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov <= n_ov;
            r_ost <= n_ost;
            r_oaddr <= n_oaddr;
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
        end
        if (accept) begin
            r_kind <= i_req_type;
            r_want <= in_want;
            r_hdr <= fofs - HDR;
        end
        r_k <= n_k; r_j <= n_j; r_cur <= n_cur; r_ins <= n_ins;
        r_mph <= n_mph;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BLOCKS))
        else $error("block count out of range");
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |=> !r_ov || $past(accept))
        else $error("double result strobe");
    a_busy_nostrobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !accept)
        else $error("request accepted while busy");
    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ost != ST_DONE) |-> (r_oaddr == '0))
        else $error("address on failed request");
endmodule

[dv/tb_top.sv]
// Self-checking testbench for first_fit_heap_allocator_core: a queue-fed driver, a
// result monitor, and an in-bench table predictor with heap_base sweeps.
// Depends on ffha_pkg and the allocator RTL.
module tb_top;
    import ffha_pkg::*;

    localparam logic [1:0] REQ_BOGUS = 2'd3;
    localparam int unsigned N_BLK  = 256;
    localparam int unsigned HEAP   = 4194304;
    localparam int unsigned HDR    = 16;
    localparam int unsigned ALN    = 16;
    localparam int unsigned MINPAY = 16;
    localparam int unsigned LIMIT  = 6000000;

    typedef struct {
        logic [1:0]  kind;
        logic [22:0] size;
        logic [31:0] addr;
    } t_req;

    typedef struct {
        logic [31:0] addr;
        logic [1:0]  status;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic [1:0]  i_req_type = '0;
    logic [22:0] i_request_size = '0;
    logic [31:0] i_free_address = '0;
    logic        o_result_valid;
    logic [31:0] o_result_address;
    logic [1:0]  o_status;

    first_fit_heap_allocator_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_request_size  (i_request_size),
        .i_free_address  (i_free_address),
        .o_result_valid  (o_result_valid),
        .o_result_address(o_result_address),
        .o_status        (o_status)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    t_req        pending_reqs[$];
    t_res        expected_results[$];
    logic [31:0] live_ptrs[$];
    logic [31:0] last_released;
    int unsigned heap_base;
    int unsigned blk_start[N_BLK];
    int unsigned blk_size[N_BLK];
    bit          blk_free[N_BLK];
    int unsigned blk_cnt;
    int          n_errors, n_results, n_accepted, n_alloc_ok, n_free_ok, n_nomem, n_ignored;
    int          max_blocks_seen;
    int unsigned cycle_count;
    int          gap;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch @%0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
        n_errors++;
    endtask

    function automatic void heap_reinit();
        blk_start[0] = 0;
        blk_size[0]  = HEAP - HDR;
        blk_free[0]  = 1'b1;
        blk_cnt      = 1;
        live_ptrs.delete();
    endfunction

    function automatic void drop_block(int unsigned k);
        for (int unsigned j = k; j + 1 < blk_cnt; j++) begin
            blk_start[j] = blk_start[j+1];
            blk_size[j]  = blk_size[j+1];
            blk_free[j]  = blk_free[j+1];
        end
        blk_cnt--;
    endfunction

    function automatic void coalesce_fwd(int unsigned k);
        while (k + 1 < blk_cnt && blk_free[k+1] &&
               blk_start[k] + HDR + blk_size[k] == blk_start[k+1]) begin
            blk_size[k] += HDR + blk_size[k+1];
            drop_block(k + 1);
        end
    endfunction

    function automatic t_res heap_alloc(logic [22:0] sz);
        t_res        r;
        int unsigned want, spare, ns;
        r.addr = '0;
        if (sz == 0) begin
            r.status = ST_ZERO;
            return r;
        end
        want = ((int'(sz) + ALN - 1) / ALN) * ALN;
        for (int unsigned k = 0; k < blk_cnt; k++) begin
            if (!blk_free[k] || blk_size[k] < want) continue;
            spare = blk_size[k] - want;
            if (spare >= HDR + MINPAY + ALN - 1 && blk_cnt < N_BLK) begin
                ns = blk_start[k] + HDR + want;
                if (ns + HDR > HEAP) begin
                    r.status = ST_NOMEM;
                    return r;
                end
                for (int j = int'(blk_cnt) - 1; j > int'(k); j--) begin
                    blk_start[j+1] = blk_start[j];
                    blk_size[j+1]  = blk_size[j];
                    blk_free[j+1]  = blk_free[j];
                end
                blk_start[k+1] = ns;
                blk_size[k+1]  = ((spare - HDR) / ALN) * ALN;
                blk_free[k+1]  = 1'b1;
                blk_cnt++;
            end
            blk_free[k] = 1'b0;
            blk_size[k] = want;
            r.addr = 32'(heap_base + blk_start[k] + HDR);
            r.status = ST_DONE;
            return r;
        end
        r.status = ST_NOMEM;
        return r;
    endfunction

    function automatic logic [1:0] heap_release(logic [31:0] ptr);
        logic [31:0] off;
        int unsigned k;
        if (ptr == 0 || ptr % ALN != 0) return ST_IGNORED;
        off = ptr - heap_base;
        if (off >= HEAP || off < HDR) return ST_IGNORED;
        for (k = 0; k < blk_cnt; k++)
            if (blk_start[k] == off - HDR) break;
        if (k >= blk_cnt || blk_free[k]) return ST_IGNORED;
        blk_free[k] = 1'b1;
        coalesce_fwd(k);
        if (k > 0 && blk_free[k-1] && blk_start[k-1] + HDR + blk_size[k-1] == blk_start[k]) begin
            blk_size[k-1] += HDR + blk_size[k];
            drop_block(k);
            coalesce_fwd(k - 1);
        end
        for (int i = 0; i < live_ptrs.size(); i++)
            if (live_ptrs[i] == ptr) begin
                live_ptrs.delete(i);
                break;
            end
        last_released = ptr;
        return ST_DONE;
    endfunction

    function automatic void predict_request(t_req q);
        t_res r;
        r.addr = '0;
        case (q.kind)
            REQ_ALLOC: begin
                r = heap_alloc(q.size);
                if (r.status == ST_DONE) begin
                    live_ptrs.push_back(r.addr);
                    n_alloc_ok++;
                end
            end
            REQ_FREE: begin
                r.status = heap_release(q.addr);
                if (r.status == ST_DONE) n_free_ok++;
            end
            REQ_INIT: begin
                heap_reinit();
                r.status = ST_DONE;
            end
            default:   r.status = ST_IGNORED;
        endcase
        if (blk_cnt > max_blocks_seen) max_blocks_seen = blk_cnt;
        expected_results.push_back(r);
    endfunction

    // driver: hold start until accepted, then draw a gap before the next request
    always @(posedge i_clk) begin
        t_req q;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap   <= 0;
        end else if (start && !busy) begin
            predict_request(t_req'{i_req_type, i_request_size, i_free_address});
            n_accepted++;
            gap = $urandom_range(0, 6);
            if (gap == 0 && pending_reqs.size() > 0) begin
                q = pending_reqs.pop_front();
                i_req_type     <= q.kind;
                i_request_size <= q.size;
                i_free_address <= q.addr;
            end else begin
                start <= 1'b0;
            end
        end else if (!start) begin
            if (gap > 0) begin
                gap <= gap - 1;
            end else if (pending_reqs.size() > 0) begin
                q = pending_reqs.pop_front();
                i_req_type     <= q.kind;
                i_request_size <= q.size;
                i_free_address <= q.addr;
                start          <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n && o_result_valid) begin
            n_results++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_result_address, 32'h0);
            end else begin
                w = expected_results.pop_front();
                if (o_result_address !== w.addr)
                    report_mismatch("result_address", o_result_address, w.addr);
                if (o_status !== w.status)
                    report_mismatch("status", 32'(o_status), 32'(w.status));
                if (w.status == ST_NOMEM) n_nomem++;
                if (w.status == ST_IGNORED) n_ignored++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic push_req(input logic [1:0] k, input logic [22:0] s, input logic [31:0] a);
        pending_reqs.push_back(t_req'{k, s, a});
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        heap_base = v;
    endtask

    function automatic logic [22:0] pick_size();
        int unsigned p = $urandom_range(0, 99);
        if (p < 3)  return '0;
        if (p < 70) return 23'($urandom_range(1, 256));
        if (p < 90) return 23'($urandom_range(1, 65536));
        if (p < 98) return 23'($urandom_range(1, 1 << 20));
        return 23'($urandom);
    endfunction

    function automatic logic [31:0] pick_ptr();
        int unsigned p = $urandom_range(0, 99);
        if (p < 75 && live_ptrs.size() > 0)
            return live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
        if (p < 85) return last_released;
        if (p < 92) return heap_base + 32'($urandom_range(0, HEAP / ALN) * ALN);
        return $urandom;
    endfunction

    // mixed traffic in small batches so frees can target live blocks
    task automatic run_mix(input int n);
        int done_cnt = 0;
        int batch, p;
        while (done_cnt < n) begin
            batch = $urandom_range(1, 16);
            for (int i = 0; i < batch; i++) begin
                p = $urandom_range(0, 99);
                if (p < 52)      push_req(REQ_ALLOC, pick_size(), $urandom);
                else if (p < 92) push_req(REQ_FREE, 23'($urandom), pick_ptr());
                else if (p < 96) push_req(REQ_INIT, 23'($urandom), $urandom);
                else             push_req(REQ_BOGUS, 23'($urandom), $urandom);
            end
            done_cnt += batch;
            while (pending_reqs.size() > 0) @(posedge i_clk);
        end
        wait_idle();
    endtask

    initial begin
        logic [31:0] bases[6];
        n_errors = 0;
        cycle_count = 0;
        last_released = '0;
        heap_base = 0;
        heap_reinit();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_req(REQ_ALLOC, 23'd0, '0);
        push_req(REQ_ALLOC, 23'd1, '0);
        push_req(REQ_ALLOC, 23'd16, '0);
        push_req(REQ_ALLOC, 23'd17, '0);
        push_req(REQ_ALLOC, 23'd4194304, '0);
        push_req(REQ_ALLOC, 23'h7FFFFF, '0);
        push_req(REQ_FREE, '0, 32'd0);
        push_req(REQ_FREE, '0, 32'd24);
        push_req(REQ_FREE, '0, 32'd0 + 32'd8);
        push_req(REQ_FREE, '0, 32'(HEAP));
        push_req(REQ_FREE, '0, 32'h1000);
        push_req(REQ_FREE, '0, 32'd16);
        push_req(REQ_FREE, '0, 32'd16);
        push_req(REQ_FREE, '0, 32'd80);
        push_req(REQ_FREE, '0, 32'd48);
        push_req(REQ_BOGUS, 23'h7FFFFF, 32'hFFFF_FFFF);
        push_req(REQ_ALLOC, 23'd4194256, '0);
        push_req(REQ_ALLOC, 23'd1, '0);
        push_req(REQ_INIT, '0, '0);
        push_req(REQ_ALLOC, 23'd4194288, '0);
        push_req(REQ_INIT, '0, '0);
        wait_idle();

        // fill the table past its capacity, then release in random order
        for (int i = 0; i < 270; i++) push_req(REQ_ALLOC, 23'($urandom_range(1, 48)), '0);
        wait_idle();
        while (live_ptrs.size() > 0 && pending_reqs.size() < 150)
            push_req(REQ_FREE, '0, live_ptrs[$urandom_range(0, live_ptrs.size() - 1)]);
        wait_idle();
        run_mix(60);

        bases = '{32'hFFFF_FFF0, 32'h1234_5670, 32'hFFFF_FFFF, 32'h0040_0000,
                  $urandom, 32'h0};
        foreach (bases[i]) begin
            write_base(bases[i]);
            push_req(REQ_INIT, '0, '0);
            run_mix(110);
        end

        wait_idle();
        if (expected_results.size() != 0)
            report_mismatch("results never seen", expected_results.size(), 0);
        $display("%0d requests, %0d results, %0d allocs ok, %0d frees ok, %0d out of memory,",
                 n_accepted, n_results, n_alloc_ok, n_free_ok, n_nomem);
        $display("%0d ignored, peak table size %0d, 7 heap_base settings",
                 n_ignored, max_blocks_seen);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
